// File: sv/robot_drive_mode_controller_unit_defines.svh
// Assertion macros shared by the drive mode controller RTL.
`ifndef ROBOT_DRIVE_MODE_CONTROLLER_UNIT_DEFINES_SVH
`define ROBOT_DRIVE_MODE_CONTROLLER_UNIT_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define RDMC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define RDMC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/rdmc_pkg.sv
// Types, codes and constants of the drive mode controller.
package rdmc_pkg;

  // Run modes; the LED code equals the mode code
  localparam logic [1:0] MODE_MANUAL = 2'd0;
  localparam logic [1:0] MODE_AUTO   = 2'd1;
  localparam logic [1:0] MODE_EMERG  = 2'd2;

  // Motion states
  localparam logic [2:0] MOT_STOP  = 3'd0;
  localparam logic [2:0] MOT_FWD   = 3'd1;
  localparam logic [2:0] MOT_BACK  = 3'd2;
  localparam logic [2:0] MOT_LEFT  = 3'd3;
  localparam logic [2:0] MOT_RIGHT = 3'd4;

  // Event kinds
  localparam logic [1:0] FUNC_TICK = 2'd0;
  localparam logic [1:0] FUNC_IR   = 2'd1;
  localparam logic [1:0] FUNC_JOY  = 2'd2;
  localparam logic [1:0] FUNC_LINK = 2'd3;

  // IR and link commands
  localparam logic [3:0] CMD_MANUAL = 4'd0;
  localparam logic [3:0] CMD_AUTO   = 4'd1;
  localparam logic [3:0] CMD_EMERG  = 4'd2;
  localparam logic [3:0] CMD_UP     = 4'd3;
  localparam logic [3:0] CMD_DOWN   = 4'd4;
  localparam logic [3:0] CMD_LEFT   = 4'd5;
  localparam logic [3:0] CMD_RIGHT  = 4'd6;
  localparam logic [3:0] CMD_OK     = 4'd7;
  localparam logic [3:0] CMD_OTHER  = 4'd8;

  // Joystick directions
  localparam logic [2:0] STICK_UP     = 3'd0;
  localparam logic [2:0] STICK_DOWN   = 3'd1;
  localparam logic [2:0] STICK_LEFT   = 3'd2;
  localparam logic [2:0] STICK_RIGHT  = 3'd3;
  localparam logic [2:0] STICK_CENTER = 3'd4;

  // Configuration register indexes
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] CFG_OBSTACLE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_BACKOFF  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ALARM    = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPEED    = 2'd3;

  // Configuration reset values
  localparam logic [15:0] OBSTACLE_RST = 16'd20;
  localparam logic [3:0]  BACKOFF_RST  = 4'd2;
  localparam logic [15:0] ALARM_RST    = 16'd100;
  localparam logic [7:0]  SPEED_RST    = 8'd255;

  // Turn length generator
  localparam logic [31:0] LCG_MUL      = 32'd1664525;
  localparam logic [31:0] LCG_INC      = 32'd1013904223;
  localparam logic [31:0] LCG_SEED_RST = 32'd123456789;
  localparam logic [2:0]  TURN_BASE    = 3'd4;
  localparam logic [2:0]  TURN_SAT     = 3'd7;
  localparam logic [3:0]  BACKOFF_SAT  = 4'd15;

  // Servo sweep
  localparam logic [7:0] SERVO_STEP = 8'd5;
  localparam logic [7:0] SERVO_MAX  = 8'd180;

  // Queue depths (at least two)
  localparam int QUEUE_DEPTH_DEF  = 2;
  localparam int RESULT_DEPTH_DEF = 2;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] range_mm;
    logic [3:0]  command;
    logic [2:0]  stick_dir;
    logic [7:0]  link_speed;
  } event_t;

  typedef struct packed {
    logic       motor_update;
    logic       left_backward;
    logic       right_backward;
    logic [7:0] left_speed;
    logic [7:0] right_speed;
    logic       led_update;
    logic [1:0] lamp_code;
    logic       alarm_update;
    logic       alarm_active;
    logic       servo_update;
    logic [7:0] servo_angle;
    logic [1:0] mode_now;
  } result_t;

  typedef struct packed {
    logic [15:0] obstacle_threshold_mm;
    logic [3:0]  backoff_ticks;
    logic [15:0] alarm_distance_mm;
    logic [7:0]  drive_speed;
  } cfg_t;

  // Classified event handed from the front to the back
  typedef struct packed {
    logic [1:0] func;
    logic       blocked;
    logic       alarm;
    logic       mode_cmd;
    logic [1:0] mode_code;
    logic [2:0] cmd_motion;
    logic [2:0] stick_motion;
    logic [7:0] link_speed;
  } uop_t;

endpackage

// File: sv/rdmc_front.sv
// Front end: takes event words, classifies them and queues them for the back end.
module rdmc_front #(
  parameter int DEPTH = rdmc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  rdmc_pkg::cfg_t   cfg,
  input  logic             push,
  output logic             full,
  input  rdmc_pkg::event_t evt,
  output logic             uop_valid,
  output rdmc_pkg::uop_t   uop,
  input  logic             uop_pop
);

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  rdmc_pkg::uop_t  fifo [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  rdmc_pkg::uop_t  dec;
  logic            do_push;
  logic            do_pop;

  // Classify the incoming word against the configured thresholds
  always_comb begin
    dec.func       = evt.func;
    dec.blocked    = evt.range_mm <= cfg.obstacle_threshold_mm;
    dec.alarm      = evt.range_mm < cfg.alarm_distance_mm;
    dec.mode_cmd   = evt.command <= rdmc_pkg::CMD_EMERG;
    dec.mode_code  = evt.command[1:0];
    dec.link_speed = evt.link_speed;
    unique case (evt.command)
      rdmc_pkg::CMD_UP:    dec.cmd_motion = rdmc_pkg::MOT_FWD;
      rdmc_pkg::CMD_DOWN:  dec.cmd_motion = rdmc_pkg::MOT_BACK;
      rdmc_pkg::CMD_LEFT:  dec.cmd_motion = rdmc_pkg::MOT_LEFT;
      rdmc_pkg::CMD_RIGHT: dec.cmd_motion = rdmc_pkg::MOT_RIGHT;
      default:             dec.cmd_motion = rdmc_pkg::MOT_STOP;
    endcase
    unique case (evt.stick_dir)
      rdmc_pkg::STICK_UP:    dec.stick_motion = rdmc_pkg::MOT_FWD;
      rdmc_pkg::STICK_DOWN:  dec.stick_motion = rdmc_pkg::MOT_BACK;
      rdmc_pkg::STICK_LEFT:  dec.stick_motion = rdmc_pkg::MOT_LEFT;
      rdmc_pkg::STICK_RIGHT: dec.stick_motion = rdmc_pkg::MOT_RIGHT;
      default:               dec.stick_motion = rdmc_pkg::MOT_STOP;
    endcase
  end

  assign full      = (count == FullCnt);
  assign uop_valid = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = uop_pop && uop_valid;
  assign uop       = fifo[rd_ptr];

  // Store the classified word
  always_ff @(posedge clk) begin
    if (do_push) begin
      fifo[wr_ptr] <= dec;
    end
  end

  // Advance pointers and track fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: sv/rdmc_back.sv
// Back end: runs queued events against the drive state and queues result words.
module rdmc_back #(
  parameter int DEPTH = rdmc_pkg::RESULT_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  rdmc_pkg::cfg_t    cfg,
  input  logic              uop_valid,
  input  rdmc_pkg::uop_t    uop,
  output logic              uop_pop,
  output logic              empty,
  input  logic              pop,
  output rdmc_pkg::result_t res
);

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  // Residue modulo 3 by folding digits of bases 2^16, 2^8, 2^4 and 2^2
  function automatic logic [1:0] mod3(input logic [31:0] x);
    logic [16:0] s16;
    logic [9:0]  s8;
    logic [5:0]  s4;
    logic [3:0]  f1;
    logic [2:0]  f2;
    logic [2:0]  f3;
    s16  = {1'b0, x[31:16]} + {1'b0, x[15:0]};
    s8   = {2'b0, s16[15:8]} + {2'b0, s16[7:0]} + {9'b0, s16[16]};
    s4   = {2'b0, s8[7:4]} + {2'b0, s8[3:0]} + {4'b0, s8[9:8]};
    f1   = {2'b0, s4[5:4]} + {2'b0, s4[3:2]} + {2'b0, s4[1:0]};
    f2   = {1'b0, f1[3:2]} + {1'b0, f1[1:0]};
    f3   = {1'b0, f2[1:0]} + {2'b0, f2[2]};
    mod3 = (f3 == 3'd3) ? 2'd0 : f3[1:0];
  endfunction

  // Fill the wheel fields for a motion at a speed
  function automatic rdmc_pkg::result_t drive(input rdmc_pkg::result_t r_in,
                                              input logic [2:0] mot,
                                              input logic [7:0] speed);
    rdmc_pkg::result_t r;
    r                = r_in;
    r.motor_update   = 1'b1;
    r.left_backward  = (mot == rdmc_pkg::MOT_BACK) || (mot == rdmc_pkg::MOT_LEFT);
    r.right_backward = (mot == rdmc_pkg::MOT_BACK) || (mot == rdmc_pkg::MOT_RIGHT);
    r.left_speed     = speed;
    r.right_speed    = speed;
    return r;
  endfunction

  // Drive state
  logic [1:0]  run_mode;
  logic [2:0]  motion;
  logic [3:0]  backoff_count;
  logic [2:0]  turn_count;
  logic [2:0]  turn_length;
  logic [31:0] lcg_seed;
  logic [31:0] lcg_prod;
  logic [7:0]  sweep_angle;
  logic        sweep_rising;

  logic [1:0]  run_mode_next;
  logic [2:0]  motion_next;
  logic [3:0]  backoff_count_next;
  logic [2:0]  turn_count_next;
  logic [2:0]  turn_length_next;
  logic [31:0] lcg_seed_next;
  logic [7:0]  sweep_angle_next;
  logic        sweep_rising_next;

  logic [3:0]  bc_inc;
  logic [2:0]  tc_inc;
  logic [7:0]  angle_step;
  logic        rising_step;
  logic [1:0]  ir_mode;
  rdmc_pkg::result_t r;

  // Result queue
  rdmc_pkg::result_t rfifo [DEPTH];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [CntW-1:0]   count;
  logic              rfull;
  logic              exec;
  logic              do_pop;

  assign rfull   = (count == FullCnt);
  assign exec    = uop_valid && !rfull;
  assign uop_pop = exec;
  assign empty   = (count == '0);
  assign do_pop  = pop && !empty;
  assign res     = rfifo[rd_ptr];

  // Precompute the next generator value one step ahead of use
  always_ff @(posedge clk) begin
    lcg_prod <= lcg_seed * rdmc_pkg::LCG_MUL + rdmc_pkg::LCG_INC;
  end

  // Servo sweep step
  always_comb begin
    if (sweep_rising) begin
      angle_step = sweep_angle + rdmc_pkg::SERVO_STEP;
    end else if (sweep_angle >= rdmc_pkg::SERVO_STEP) begin
      angle_step = sweep_angle - rdmc_pkg::SERVO_STEP;
    end else begin
      angle_step = '0;
    end
    rising_step = sweep_rising;
    if (angle_step >= rdmc_pkg::SERVO_MAX) begin
      angle_step  = rdmc_pkg::SERVO_MAX;
      rising_step = 1'b0;
    end else if (angle_step == '0) begin
      rising_step = 1'b1;
    end
  end

  // Execute the head event
  always_comb begin
    run_mode_next      = run_mode;
    motion_next        = motion;
    backoff_count_next = backoff_count;
    turn_count_next    = turn_count;
    turn_length_next   = turn_length;
    lcg_seed_next      = lcg_seed;
    sweep_angle_next   = sweep_angle;
    sweep_rising_next  = sweep_rising;
    ir_mode            = run_mode;
    r                  = '0;
    bc_inc = (backoff_count < rdmc_pkg::BACKOFF_SAT) ? backoff_count + 4'd1 : backoff_count;
    tc_inc = (turn_count < rdmc_pkg::TURN_SAT) ? turn_count + 3'd1 : turn_count;

    unique case (uop.func)
      rdmc_pkg::FUNC_TICK: begin
        // Obstacle avoidance in auto mode
        if (run_mode == rdmc_pkg::MODE_AUTO) begin
          if (motion == rdmc_pkg::MOT_STOP || motion == rdmc_pkg::MOT_FWD) begin
            if (uop.blocked) begin
              backoff_count_next = '0;
              motion_next        = rdmc_pkg::MOT_BACK;
            end else begin
              r = drive(r, rdmc_pkg::MOT_FWD, cfg.drive_speed);
            end
          end else if (motion == rdmc_pkg::MOT_BACK) begin
            r                  = drive(r, rdmc_pkg::MOT_BACK, cfg.drive_speed);
            backoff_count_next = bc_inc;
            if (bc_inc >= cfg.backoff_ticks) begin
              turn_count_next  = '0;
              lcg_seed_next    = lcg_prod;
              turn_length_next = rdmc_pkg::TURN_BASE + {1'b0, mod3(lcg_prod)};
              motion_next      = rdmc_pkg::MOT_LEFT;
            end
          end else if (motion == rdmc_pkg::MOT_LEFT) begin
            r               = drive(r, rdmc_pkg::MOT_LEFT, cfg.drive_speed);
            turn_count_next = tc_inc;
            if (tc_inc >= turn_length) begin
              motion_next = rdmc_pkg::MOT_FWD;
            end
          end else begin
            r = drive(r, rdmc_pkg::MOT_STOP, 8'd0);
          end
        end
        r.alarm_update = 1'b1;
        r.alarm_active = uop.alarm;
        // Sweep the servo unless stopped by emergency
        if (run_mode != rdmc_pkg::MODE_EMERG) begin
          sweep_angle_next  = angle_step;
          sweep_rising_next = rising_step;
          r.servo_update    = 1'b1;
        end
      end
      rdmc_pkg::FUNC_IR: begin
        if (uop.mode_cmd) begin
          ir_mode      = uop.mode_code;
          r.led_update = 1'b1;
          r.lamp_code  = uop.mode_code;
          r            = drive(r, rdmc_pkg::MOT_STOP, 8'd0);
          motion_next  = rdmc_pkg::MOT_STOP;
        end
        run_mode_next = ir_mode;
        if (ir_mode == rdmc_pkg::MODE_MANUAL) begin
          motion_next = uop.cmd_motion;
          r = drive(r, uop.cmd_motion,
                    (uop.cmd_motion == rdmc_pkg::MOT_STOP) ? 8'd0 : cfg.drive_speed);
        end
      end
      rdmc_pkg::FUNC_JOY: begin
        if (run_mode == rdmc_pkg::MODE_MANUAL) begin
          motion_next = uop.stick_motion;
        end
        r = drive(r, motion_next, cfg.drive_speed);
      end
      default: begin
        // Link command: steer only, no state change
        r = drive(r, uop.cmd_motion,
                  (uop.cmd_motion == rdmc_pkg::MOT_STOP) ? 8'd0 : uop.link_speed);
      end
    endcase

    r.servo_angle = sweep_angle_next;
    r.mode_now    = run_mode_next;
  end

  // Commit state when an event runs
  always_ff @(posedge clk) begin
    if (rst) begin
      run_mode      <= rdmc_pkg::MODE_MANUAL;
      motion        <= rdmc_pkg::MOT_STOP;
      backoff_count <= '0;
      turn_count    <= '0;
      turn_length   <= '0;
      lcg_seed      <= rdmc_pkg::LCG_SEED_RST;
      sweep_angle   <= '0;
      sweep_rising  <= 1'b1;
    end else if (exec) begin
      run_mode      <= run_mode_next;
      motion        <= motion_next;
      backoff_count <= backoff_count_next;
      turn_count    <= turn_count_next;
      turn_length   <= turn_length_next;
      lcg_seed      <= lcg_seed_next;
      sweep_angle   <= sweep_angle_next;
      sweep_rising  <= sweep_rising_next;
    end
  end

  // Store the result word
  always_ff @(posedge clk) begin
    if (exec) begin
      rfifo[wr_ptr] <= r;
    end
  end

  // Advance result queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (exec) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      case ({exec, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: sv/robot_drive_mode_controller_unit.sv
// Top level of the drive mode controller: configuration registers, front and back ends.
//
//   channel   handshake             payload
//   event     push / full           evt  (rdmc_pkg::event_t)
//   result    empty / pop           res  (rdmc_pkg::result_t)
//   config    cfg_valid/cfg_ready   cfg_index, cfg_data
//
// One event word per cycle sustained while the result side keeps popping; a pushed word
// waits in the event queue, is executed from its head and its result word is written to
// the result queue to be popped. The back end's per-event state update sets this rate.
// Synchronous reset restores modes, counters, seed and sweep; no clearing pass.
// A stalled result side fills the result queue, then the event queue, then raises full.
// Configuration writes are taken every cycle.
`include "robot_drive_mode_controller_unit_defines.svh"

module robot_drive_mode_controller_unit #(
  parameter int QUEUE_DEPTH  = rdmc_pkg::QUEUE_DEPTH_DEF,
  parameter int RESULT_DEPTH = rdmc_pkg::RESULT_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  rdmc_pkg::event_t                    evt,
  output logic                                empty,
  input  logic                                pop,
  output rdmc_pkg::result_t                   res,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rdmc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [rdmc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  rdmc_pkg::cfg_t cfg;
  rdmc_pkg::uop_t uop;
  logic           uop_valid;
  logic           uop_pop;

  assign cfg_ready = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.obstacle_threshold_mm <= rdmc_pkg::OBSTACLE_RST;
      cfg.backoff_ticks         <= rdmc_pkg::BACKOFF_RST;
      cfg.alarm_distance_mm     <= rdmc_pkg::ALARM_RST;
      cfg.drive_speed           <= rdmc_pkg::SPEED_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rdmc_pkg::CFG_OBSTACLE: cfg.obstacle_threshold_mm <= cfg_data;
        rdmc_pkg::CFG_BACKOFF:  cfg.backoff_ticks         <= cfg_data[3:0];
        rdmc_pkg::CFG_ALARM:    cfg.alarm_distance_mm     <= cfg_data;
        default:                cfg.drive_speed           <= cfg_data[7:0];
      endcase
    end
  end

  rdmc_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .push      (push),
    .full      (full),
    .evt       (evt),
    .uop_valid (uop_valid),
    .uop       (uop),
    .uop_pop   (uop_pop)
  );

  rdmc_back #(
    .DEPTH (RESULT_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .uop_valid (uop_valid),
    .uop       (uop),
    .uop_pop   (uop_pop),
    .empty     (empty),
    .pop       (pop),
    .res       (res)
  );

  // An accepted word is held in one of the two queues on the next cycle
  `RDMC_ASSERT_NEXT(a_word_held, clk, rst, push && !full, uop_valid || !empty, "event word lost")
  // A mode change reports the same code on the LED and the mode field
  `RDMC_ASSERT_NOW(a_lamp_code, clk, rst, !empty && res.led_update, res.lamp_code == res.mode_now, "LED code differs from mode")
  // The sweep never leaves its range
  `RDMC_ASSERT_NOW(a_servo_range, clk, rst, !empty, res.servo_angle <= rdmc_pkg::SERVO_MAX, "servo angle out of range")

endmodule
